[hw/rtl/fdc_pkg.sv]
// Shared widths and types of the frame distinct compactor.
package fdc_pkg;

  localparam int SAMPLE_W = 16;

  // Status of the sample queue as seen by the back end
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] data;
  } q_stat_t;

endpackage

[hw/rtl/fdc_front.sv]
// Front end: accepts sample words and holds them in a two-entry queue.
module fdc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fdc_pkg::SAMPLE_W-1:0] sample_value,
  output logic                        busy,
  input  logic                        pop,
  output fdc_pkg::q_stat_t            q_stat
);

  logic [fdc_pkg::SAMPLE_W-1:0] slot [2];
  logic                         wr_ptr;
  logic                         rd_ptr;
  logic [1:0]                   fill;
  logic                         push;
  logic                         do_pop;

  assign busy   = (fill == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (fill != 2'd0);

  assign q_stat.valid = (fill != 2'd0);
  assign q_stat.data  = slot[rd_ptr];

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= sample_value;
    end
  end

endmodule

[hw/rtl/fdc_back.sv]
// Back end: searches the seen table, stores new values and emits results and padding.
module fdc_back #(
  parameter int FRAME_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fdc_pkg::q_stat_t             q_stat,
  output logic                         pop,
  output logic                         strobe,
  output logic [fdc_pkg::SAMPLE_W-1:0] out_value,
  output logic                         filled,
  output logic                         frame_end
);

  localparam int AW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam int CW = $clog2(FRAME_LEN + 1);
  localparam logic [CW-1:0] LEN_C  = CW'(FRAME_LEN);
  localparam logic [CW-1:0] LAST_C = CW'(FRAME_LEN - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CMP  = 5'b00100,
    S_WRAP = 5'b01000,
    S_PAD  = 5'b10000
  } state_t;

  state_t                       state;
  logic [fdc_pkg::SAMPLE_W-1:0] cur;
  logic [fdc_pkg::SAMPLE_W-1:0] rd_data;
  logic [fdc_pkg::SAMPLE_W-1:0] seen_table [FRAME_LEN];
  logic [CW-1:0]                idx;
  logic [CW-1:0]                count;
  logic [CW-1:0]                position;
  logic                         found;
  logic [CW-1:0]                count_next;
  logic                         rd_en;
  logic                         wr_en;

  assign pop        = (state == S_IDLE) && q_stat.valid;
  assign count_next = found ? count : count + CW'(1);
  assign rd_en      = (state == S_READ) && (idx != count);
  assign wr_en      = (state == S_WRAP) && !found;

  // Seen table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seen_table[count[AW-1:0]] <= cur;
    end
    if (rd_en) begin
      rd_data <= seen_table[idx[AW-1:0]];
    end
  end

  // Search sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      position  <= '0;
      idx       <= '0;
      found     <= 1'b0;
      strobe    <= 1'b0;
      filled    <= 1'b0;
      frame_end <= 1'b0;
      out_value <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_stat.valid) begin
            cur   <= q_stat.data;
            idx   <= '0;
            found <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          // end of stored entries: value is new
          if (idx == count) begin
            state <= S_WRAP;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_data == cur) begin
            found <= 1'b1;
            state <= S_WRAP;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_WRAP: begin
          if (!found) begin
            strobe    <= 1'b1;
            out_value <= cur;
            filled    <= 1'b1;
            frame_end <= (count_next == LEN_C);
          end
          if (position == LAST_C) begin
            if (count_next == LEN_C) begin
              count    <= '0;
              position <= '0;
              state    <= S_IDLE;
            end else begin
              count <= count_next;
              idx   <= count_next;
              state <= S_PAD;
            end
          end else begin
            position <= position + CW'(1);
            count    <= count_next;
            state    <= S_IDLE;
          end
        end
        S_PAD: begin
          strobe    <= 1'b1;
          out_value <= '0;
          filled    <= 1'b0;
          frame_end <= (idx == LAST_C);
          if (idx == LAST_C) begin
            count    <= '0;
            position <= '0;
            state    <= S_IDLE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/frame_distinct_compactor_top.sv]
// Top level of the frame distinct compactor.
// Each frame is FRAME_LEN sample words. A word is taken when start is high and busy is
// low; a two-word queue lets the sender run ahead while the search is working. The first
// occurrence of a value in the frame comes out on the next free result slot with filled
// high; repeats give nothing. After the frame's last sample, padding words (filled low,
// out_value zero) follow on consecutive cycles until the frame has given FRAME_LEN
// results, and the last carries frame_end. Results appear for exactly one cycle under
// strobe; the receiver cannot stall them. The seen table has one registered read port,
// so each stored entry is searched in a read state and then a compare state. A new value
// is read against every stored entry and then written; a repeat stops at the match. The
// back end takes no new sample until it is done with the last one, and after the final
// sample of a frame it first emits all the padding words.
module frame_distinct_compactor_top #(
  parameter int FRAME_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fdc_pkg::SAMPLE_W-1:0] sample_value,
  output logic                         busy,
  output logic                         strobe,
  output logic [fdc_pkg::SAMPLE_W-1:0] out_value,
  output logic                         filled,
  output logic                         frame_end
);

  fdc_pkg::q_stat_t q_stat;
  logic             pop;

  fdc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sample_value (sample_value),
    .busy         (busy),
    .pop          (pop),
    .q_stat       (q_stat)
  );

  fdc_back #(
    .FRAME_LEN (FRAME_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop       (pop),
    .strobe    (strobe),
    .out_value (out_value),
    .filled    (filled),
    .frame_end (frame_end)
  );

endmodule

[hw/rtl/fdc_checker.sv]
// Port-level checker for the frame distinct compactor, bound to the top level.
module fdc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic [fdc_pkg::SAMPLE_W-1:0] sample_value,
  input logic                         busy,
  input logic                         strobe,
  input logic [fdc_pkg::SAMPLE_W-1:0] out_value,
  input logic                         filled,
  input logic                         frame_end
);

  // No result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result strobe right after reset");

  // An accepted word carries a known sample
  a_accept_known: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !$isunknown(sample_value))
    else $error("accepted word with unknown sample");

  // Padding words carry a zero value
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !filled) |-> (out_value == '0))
    else $error("padding word with nonzero value");

  // Padding runs on consecutive cycles up to the frame end
  a_pad_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && !filled && !frame_end) |=> (strobe && !filled))
    else $error("padding run broken");

  // Frame end is followed by an idle result cycle
  a_end_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && frame_end) |=> !strobe)
    else $error("result right after frame end");

endmodule

bind frame_distinct_compactor_top fdc_checker u_fdc_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the frame distinct compactor top level.
`timescale 1ns / 100ps

module testbench;

  localparam int SAMPLE_W       = fdc_pkg::SAMPLE_W;
  localparam int FRAME_LEN      = 16;
  localparam int RANDOM_FRAMES  = 18;
  localparam int SETTLE_CYCLES  = 80;
  localparam int MAX_REPORTS    = 10;
  localparam int RUN_LIMIT_NS   = 6_000_000;

  // One sample word waiting to be sent; hold_for_drain makes the sender wait
  // until every outstanding result has come back.
  typedef struct packed {
    logic                hold_for_drain;
    logic [SAMPLE_W-1:0] value;
  } sample_word_t;

  // One result slot of a frame
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                filled;
    logic                last;
  } frame_slot_t;

  logic                clk;
  logic                rst;
  logic                start = 1'b0;
  logic [SAMPLE_W-1:0] sample_value = '0;
  logic                busy;
  logic                strobe;
  logic [SAMPLE_W-1:0] out_value;
  logic                filled;
  logic                frame_end;

  sample_word_t  sample_backlog[$];
  frame_slot_t   expected_slots[$];
  sample_word_t  next_word;
  int            words_queued;
  int            words_sent;
  int            mismatch_count;
  int            burst_left;
  int            gap_left;

  // Predictor state: distinct values of the current frame in first-seen order
  logic [SAMPLE_W-1:0] seen_values[FRAME_LEN];
  int                  seen_count;
  int                  frame_pos;

  frame_distinct_compactor_top #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sample_value (sample_value),
    .busy         (busy),
    .strobe       (strobe),
    .out_value    (out_value),
    .filled       (filled),
    .frame_end    (frame_end)
  );

  // Work out the result slots one accepted sample gives, in order
  task automatic predict_compacted_slots(input logic [SAMPLE_W-1:0] v);
    bit          found;
    frame_slot_t slot;
    found = 1'b0;
    for (int i = 0; i < seen_count; i++) begin
      if (seen_values[i] == v) found = 1'b1;
    end
    if (!found && seen_count < FRAME_LEN) begin
      seen_values[seen_count] = v;
      seen_count++;
      slot.value  = v;
      slot.filled = 1'b1;
      slot.last   = (seen_count == FRAME_LEN);
      expected_slots.push_back(slot);
    end
    frame_pos++;
    // frame complete: pad out to FRAME_LEN slots
    if (frame_pos >= FRAME_LEN) begin
      for (int i = seen_count; i < FRAME_LEN; i++) begin
        slot.value  = '0;
        slot.filled = 1'b0;
        slot.last   = (i == FRAME_LEN - 1);
        expected_slots.push_back(slot);
      end
      seen_count = 0;
      frame_pos  = 0;
    end
  endtask

  task automatic queue_word(input logic [SAMPLE_W-1:0] v, input bit drain);
    sample_word_t w;
    w.value          = v;
    w.hold_for_drain = drain;
    sample_backlog.push_back(w);
    words_queued++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Reset, stimulus and end of run
  initial begin
    logic [SAMPLE_W-1:0] pool[FRAME_LEN];
    int                  pool_size;
    int                  mode;
    rst            = 1'b1;
    words_queued   = 0;
    words_sent     = 0;
    mismatch_count = 0;
    seen_count     = 0;
    frame_pos      = 0;

    // Frame of all distinct values, field extremes and alternating bits
    queue_word(16'h0000, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h5555, 1'b0);
    queue_word(16'hAAAA, 1'b0);
    for (int i = 0; i < FRAME_LEN - 4; i++) queue_word(16'h0001 << i, 1'b0);
    // Frame of one repeated value: final sample is a repeat, most padding
    for (int i = 0; i < FRAME_LEN; i++) queue_word(16'hFFFF, i == 0);

    // Random frames with values drawn fresh or from pools of varying size
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      mode      = $urandom_range(0, 3);
      pool_size = (mode == 0) ? FRAME_LEN :
                  (mode == 1) ? $urandom_range(1, 3) : $urandom_range(4, FRAME_LEN);
      for (int i = 0; i < pool_size; i++) pool[i] = SAMPLE_W'($urandom_range(0, 16'hFFFF));
      for (int i = 0; i < FRAME_LEN; i++) begin
        queue_word((mode == 0) ? SAMPLE_W'($urandom_range(0, 16'hFFFF)) :
                   pool[$urandom_range(0, pool_size - 1)],
                   (i == 0) && ($urandom_range(0, 5) == 0));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (words_sent == words_queued && expected_slots.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_slots.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout: %0d of %0d words sent, %0d results outstanding",
             words_sent, words_queued, expected_slots.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Driver: sends words in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        predict_compacted_slots(sample_value);
        words_sent++;
      end
      // free to present a new word unless the current one is still held
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (sample_backlog.size() > 0 &&
                     !(sample_backlog[0].hold_for_drain && expected_slots.size() > 0)) begin
          next_word = sample_backlog.pop_front();
          start        <= 1'b1;
          sample_value <= next_word.value;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
              burst_left = $urandom_range(40, 80);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 20);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expected slot
  always @(posedge clk) begin
    frame_slot_t want;
    if (!rst && strobe) begin
      if (expected_slots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result value=%h filled=%b frame_end=%b",
                   $realtime, out_value, filled, frame_end);
      end else begin
        want = expected_slots.pop_front();
        if (out_value !== want.value || filled !== want.filled ||
            frame_end !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected value=%h filled=%b frame_end=%b, got %h %b %b",
                     $realtime, want.value, want.filled, want.last,
                     out_value, filled, frame_end);
        end
      end
    end
  end

endmodule
